[src/assert_macros.svh]
// Assertion macros used by the top module of the closest-neighbour volume search.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock and active-low reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent assertion on the usual clock and reset of this project.
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

[src/cnvs_pkg.sv]
// Types and constants shared by the closest-neighbour volume search modules.
`timescale 1ns / 1ps

package cnvs_pkg;

  localparam int CoordW  = 19;
  localparam int OffsetW = 18;
  localparam int IdxW    = 4;
  localparam int OpW     = 2;

  localparam logic [OpW-1:0] OpWrite    = 2'd0;
  localparam logic [OpW-1:0] OpClosest  = 2'd1;
  localparam logic [OpW-1:0] OpAdjacent = 2'd2;

  typedef struct packed {
    logic signed [CoordW-1:0] z;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] x;
  } centre_t;

endpackage

[src/cnvs_table.sv]
// Centre table memory with per-entry valid bits and one registered read port.
`timescale 1ns / 1ps

module cnvs_table #(
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [AddrW-1:0]     wr_addr_i,
  input  cnvs_pkg::centre_t    wr_centre_i,
  input  logic                 rd_en_i,
  input  logic [AddrW-1:0]     rd_addr_i,
  output cnvs_pkg::centre_t    rd_centre_o,
  output logic                 rd_valid_o
);

  cnvs_pkg::centre_t mem_q [Depth];
  logic [Depth-1:0]  valid_q;
  cnvs_pkg::centre_t rd_centre_q;
  logic              rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_centre_i;
    end
    if (rd_en_i) begin
      rd_centre_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_centre_o = rd_centre_q;
  assign rd_valid_o  = rd_valid_q;

endmodule

[src/closest_neighbour_volume_search_top.sv]
// A write answers without a table scan; a closest query reads the queried entry, then
// scans the whole table, and an adjacency query runs four such read-and-scan passes.
// Requests are taken one at a time; each scan reads the single table port once per entry,
// plus one read of the queried entry.
// The next request is taken in the cycle the answer is presented, once the output is free.
// Reset clears all valid bits at once, sets max_offset to 300 and empties the output.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module closest_neighbour_volume_search_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [17:0] cfg_wdata_i,     // max_offset
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // entry_index, second_index, center_x, center_y, center_z, look_positive, zero pad
  input  logic [71:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,    // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata     // found, closest_index, adjacent, zero pad
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(TABLE_DEPTH - 1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRdQ  = 3'd1;
  localparam logic [2:0] StCapQ = 3'd2;
  localparam logic [2:0] StScan = 3'd3;
  localparam logic [2:0] StStep = 3'd4;
  localparam logic [2:0] StFin  = 3'd5;

  logic [2:0]                state_q, state_d;
  logic [cnvs_pkg::OpW-1:0]  op_q, op_d;
  logic [cnvs_pkg::IdxW-1:0] a_q, a_d, b_q, b_d;
  logic                      pos_q, pos_d;
  logic [1:0]                step_q, step_d;
  logic [AW-1:0]             cnt_q, cnt_d;
  logic                      qvalid_q, qvalid_d;
  cnvs_pkg::centre_t         qc_q, qc_d;
  logic                      pv_q, pv_d;
  logic [AW-1:0]             pidx_q, pidx_d;
  logic                      have_q, have_d;
  logic [19:0]               bdx_q, bdx_d;
  logic [AW-1:0]             bidx_q, bidx_d;
  logic [3:0]                hits_q, hits_d;
  logic                      rf_q, rf_d, ra_q, ra_d;
  logic [cnvs_pkg::IdxW-1:0] ri_q, ri_d;
  logic                      mv_q, mv_d, mf_q, mf_d, ma_q, ma_d;
  logic [cnvs_pkg::IdxW-1:0] mi_q, mi_d;
  logic [17:0]               maxoff_q;

  logic                      s_acc;
  logic [cnvs_pkg::OpW-1:0]  in_op;
  logic [cnvs_pkg::IdxW-1:0] in_a, in_b;
  cnvs_pkg::centre_t         in_centre;
  logic                      wr_en;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  cnvs_pkg::centre_t         rd_centre;
  logic                      rd_valid;

  logic [cnvs_pkg::IdxW-1:0] cur_idx;
  logic                      cur_pos;
  logic                      cur_in_range;
  logic [AW-1:0]             cur_addr;
  logic [19:0]               ddx, ddy, ddz, adx, ady, adz;
  logic                      keep, take;
  logic                      found_s;
  logic [cnvs_pkg::IdxW-1:0] idx_s;
  logic                      hit_s;

  assign in_op       = s_axis_tuser;
  assign in_a        = s_axis_tdata[3:0];
  assign in_b        = s_axis_tdata[7:4];
  assign in_centre.x = s_axis_tdata[26:8];
  assign in_centre.y = s_axis_tdata[45:27];
  assign in_centre.z = s_axis_tdata[64:46];

  assign s_axis_tready = (state_q == StIdle);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign wr_en         = s_acc && (in_op == cnvs_pkg::OpWrite) && (32'(in_a) < TABLE_DEPTH);

  assign cur_idx      = (op_q == cnvs_pkg::OpClosest) ? a_q : (step_q[0] ? a_q : b_q);
  assign cur_pos      = (op_q == cnvs_pkg::OpClosest) ? pos_q :
                        ((step_q == 2'd0) || (step_q == 2'd3));
  assign cur_in_range = (32'(cur_idx) < TABLE_DEPTH);
  assign cur_addr     = AW'(cur_idx);

  assign rd_en   = (state_q == StRdQ) || (state_q == StScan);
  assign rd_addr = (state_q == StRdQ) ? cur_addr : cnt_q;

  cnvs_table #(
    .Depth (TABLE_DEPTH),
    .AddrW (AW)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_addr_i   (AW'(in_a)),
    .wr_centre_i (in_centre),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .rd_centre_o (rd_centre),
    .rd_valid_o  (rd_valid)
  );

  // Candidate test on the entry read in the previous cycle.
  always_comb begin
    ddx  = {rd_centre.x[18], rd_centre.x} - {qc_q.x[18], qc_q.x};
    ddy  = {rd_centre.y[18], rd_centre.y} - {qc_q.y[18], qc_q.y};
    ddz  = {rd_centre.z[18], rd_centre.z} - {qc_q.z[18], qc_q.z};
    adx  = ddx[19] ? (~ddx + 20'd1) : ddx;
    ady  = ddy[19] ? (~ddy + 20'd1) : ddy;
    adz  = ddz[19] ? (~ddz + 20'd1) : ddz;
    keep = rd_valid && (pidx_q != cur_addr) && (cur_pos == (rd_centre.x > qc_q.x)) &&
           (ady <= {2'b00, maxoff_q}) && (adz <= {2'b00, maxoff_q});
    take = pv_q && keep && (!have_q || (adx < bdx_q));
    have_d = have_q || take;
    bdx_d  = take ? adx : bdx_q;
    bidx_d = take ? pidx_q : bidx_q;
  end

  assign found_s = qvalid_q && have_d;
  assign idx_s   = found_s ? cnvs_pkg::IdxW'(bidx_d) : '0;
  assign hit_s   = found_s && (idx_s == (step_q[0] ? b_q : a_q));

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    a_d      = a_q;
    b_d      = b_q;
    pos_d    = pos_q;
    step_d   = step_q;
    cnt_d    = cnt_q;
    qvalid_d = qvalid_q;
    qc_d     = qc_q;
    pv_d     = 1'b0;
    pidx_d   = pidx_q;
    hits_d   = hits_q;
    rf_d     = rf_q;
    ri_d     = ri_q;
    ra_d     = ra_q;
    mv_d     = mv_q && !m_axis_tready;
    mf_d     = mf_q;
    mi_d     = mi_q;
    ma_d     = ma_q;
    unique case (state_q)
      StIdle: begin
        if (s_acc) begin
          op_d   = in_op;
          a_d    = in_a;
          b_d    = in_b;
          pos_d  = s_axis_tdata[65];
          step_d = 2'd0;
          rf_d   = 1'b0;
          ri_d   = '0;
          ra_d   = 1'b0;
          if ((in_op == cnvs_pkg::OpClosest) || (in_op == cnvs_pkg::OpAdjacent)) begin
            state_d = StRdQ;
          end else begin
            state_d = StFin;
          end
        end
      end
      StRdQ: begin
        state_d = StCapQ;
      end
      StCapQ: begin
        qc_d     = rd_centre;
        qvalid_d = rd_valid && cur_in_range;
        cnt_d    = '0;
        state_d  = StScan;
      end
      StScan: begin
        pv_d   = 1'b1;
        pidx_d = cnt_q;
        cnt_d  = cnt_q + AW'(1);
        if (cnt_q == LastIdx) begin
          state_d = StStep;
        end
      end
      StStep: begin
        if (op_q == cnvs_pkg::OpClosest) begin
          rf_d    = found_s;
          ri_d    = idx_s;
          state_d = StFin;
        end else begin
          hits_d[step_q] = hit_s;
          if (step_q == 2'd3) begin
            ra_d    = (hits_q[0] && hits_q[1]) || (hits_q[2] && hit_s);
            state_d = StFin;
          end else begin
            step_d  = step_q + 2'd1;
            state_d = StRdQ;
          end
        end
      end
      StFin: begin
        if (!mv_q || m_axis_tready) begin
          mv_d    = 1'b1;
          mf_d    = rf_q;
          mi_d    = ri_q;
          ma_d    = ra_q;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      pv_q     <= 1'b0;
      have_q   <= 1'b0;
      mv_q     <= 1'b0;
      maxoff_q <= 18'd300;
    end else begin
      state_q <= state_d;
      pv_q    <= pv_d;
      have_q  <= (state_q == StCapQ) ? 1'b0 : have_d;
      mv_q    <= mv_d;
      if (cfg_we_i) begin
        maxoff_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    a_q      <= a_d;
    b_q      <= b_d;
    pos_q    <= pos_d;
    step_q   <= step_d;
    cnt_q    <= cnt_d;
    qvalid_q <= qvalid_d;
    qc_q     <= qc_d;
    pidx_q   <= pidx_d;
    bdx_q    <= bdx_d;
    bidx_q   <= bidx_d;
    hits_q   <= hits_d;
    rf_q     <= rf_d;
    ri_q     <= ri_d;
    ra_q     <= ra_d;
    mf_q     <= mf_d;
    mi_q     <= mi_d;
    ma_q     <= ma_d;
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = {2'b00, ma_q, mi_q, mf_q};

  `ASSERT_STD(a_scan_only_while_busy,
    pv_q |-> ((state_q == StScan) || (state_q == StStep)),
    "Table data processed outside a scan")
  `ASSERT_STD(a_no_found_with_adjacent,
    m_axis_tvalid |-> !(mf_q && ma_q),
    "Closest and adjacency answers both set")
  `ASSERT_STD(a_scan_enters_step,
    (state_q == StScan) && (cnt_q == LastIdx) |=> (state_q == StStep) && pv_q,
    "Scan did not close on its last entry")
  `ASSERT_STD(a_not_found_zero_index,
    m_axis_tvalid && !mf_q |-> (mi_q == '0),
    "Index reported without a neighbour")

endmodule
